>>> design/scsjd_pkg.sv
// Shared types, constants and helpers for the size-class shortest-job dispatcher.
// Used by scsjd_cell, scsjd_queue and size_class_shortest_job_dispatch_unit.
// No dependencies.
package scsjd_pkg;

   localparam int DEF_CLASS_DEPTH = 16;
   localparam int DEF_NUM_CLASSES = 6;
   localparam int MAX_CLASSES     = 6;
   localparam int CLASS_BASE_KB   = 8;

   localparam int ID_W     = 8;
   localparam int BURST_W  = 16;
   localparam int MEM_W    = 10;
   localparam int CLASS_W  = 3;
   localparam int STATUS_W = 3;

   localparam int REQ_DATA_BITS = ID_W + BURST_W + MEM_W;
   localparam int REQ_TDATA_W   = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ID_W + BURST_W + CLASS_W;
   localparam int RSP_TDATA_W   = ((RSP_DATA_BITS + 7) / 8) * 8;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED      = 3'd0,
      STAT_TOO_BIG    = 3'd1,
      STAT_CLASS_FULL = 3'd2,
      STAT_ZERO_BURST = 3'd3,
      STAT_RAN        = 3'd4,
      STAT_FINISHED   = 3'd5,
      STAT_IDLE       = 3'd6
   } status_type;

   typedef enum logic {
      FSM_WAIT = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] burst;
   } job_type;

   typedef struct packed {
      logic    insert;
      logic    pop;
      job_type job;
   } queue_ctrl_type;

   function automatic logic [CLASS_W-1:0] pick_class(input logic [MEM_W-1:0] mem);
      logic [CLASS_W-1:0] cls;
      logic               found;
      cls   = CLASS_W'(MAX_CLASSES);
      found = 1'b0;
      for (int c = 0; c < MAX_CLASSES; c++) begin
         if (!found && (mem <= MEM_W'(CLASS_BASE_KB << c))) begin
            cls   = CLASS_W'(c);
            found = 1'b1;
         end
      end
      return cls;
   endfunction

endpackage

>>> design/size_class_shortest_job_dispatch_unit.sv
// Size-class shortest-job dispatcher with one core. A request is first registered in the
// WAIT state; then, in the EXEC state, every slot of the addressed class row compares
// against the new job and shifts in parallel (or the chosen row shifts out its head on a
// tick). The result sits in an output register, so a new request is taken while the
// previous response still waits; execution holds only while that register is full. A
// request waits until the last has executed. Depends on scsjd_pkg and scsjd_queue.
module size_class_shortest_job_dispatch_unit #(
   parameter int CLASS_DEPTH = scsjd_pkg::DEF_CLASS_DEPTH,
   parameter int NUM_CLASSES = scsjd_pkg::DEF_NUM_CLASSES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // process_id [7:0], burst [23:8], memory_kb [33:24], zero fill above
   input  logic [scsjd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // command [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // running_id [7:0], remaining_burst [23:8], class_index [26:24], zero fill above
   output logic [scsjd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status [2:0]
   output logic [scsjd_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int ID_W    = scsjd_pkg::ID_W;
   localparam int BURST_W = scsjd_pkg::BURST_W;
   localparam int MEM_W   = scsjd_pkg::MEM_W;
   localparam int CLASS_W = scsjd_pkg::CLASS_W;
   localparam logic [CLASS_W-1:0] NumClassesCode = CLASS_W'(NUM_CLASSES);

   scsjd_pkg::fsm_type   fsm_ff, fsm_in;
   scsjd_pkg::cmd_type   cmd_ff;
   scsjd_pkg::job_type   req_job_ff;
   logic [MEM_W-1:0]     mem_ff;

   logic                 busy_ff, busy_in;
   logic [ID_W-1:0]      cur_id_ff, cur_id_in;
   logic [BURST_W-1:0]   cur_rem_ff, cur_rem_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   scsjd_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [BURST_W-1:0]   rsp_rem_ff, rsp_rem_in;
   logic [CLASS_W-1:0]   rsp_cls_ff, rsp_cls_in;

   logic                 take_req;
   logic                 do_exec;

   scsjd_pkg::queue_ctrl_type q_ctrl     [NUM_CLASSES];
   logic                      q_head_vld [NUM_CLASSES];
   scsjd_pkg::job_type        q_head_job [NUM_CLASSES];
   logic                      q_full     [NUM_CLASSES];

   logic [CLASS_W-1:0]   cls;
   logic                 too_big, zero_burst, cls_full, add_ok;
   logic [NUM_CLASSES-1:0] sel_vec, pick_vec;
   logic                 picked;
   scsjd_pkg::job_type   pick_job;
   logic                 eff_busy;
   logic [ID_W-1:0]      eff_id;
   logic [BURST_W-1:0]   eff_rem;

   genvar g;
   generate
      for (g = 0; g < NUM_CLASSES; g++) begin : g_class
         scsjd_queue #(
            .DEPTH (CLASS_DEPTH)
         ) u_queue (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (q_ctrl[g]),
            .head_valid (q_head_vld[g]),
            .head_job   (q_head_job[g]),
            .full       (q_full[g])
         );
      end
   endgenerate

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         scsjd_pkg::FSM_WAIT: begin
            if (req_tvalid) fsm_in = scsjd_pkg::FSM_EXEC;
         end
         scsjd_pkg::FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) fsm_in = scsjd_pkg::FSM_WAIT;
         end
         default: fsm_in = scsjd_pkg::FSM_WAIT;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      do_exec    = 1'b0;
      unique case (fsm_ff)
         scsjd_pkg::FSM_WAIT: req_tready = 1'b1;
         scsjd_pkg::FSM_EXEC: do_exec    = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            do_exec    = 1'b0;
         end
      endcase
   end

   assign take_req = req_tvalid && req_tready;

   // class decode and add checks
   always_comb begin
      cls        = scsjd_pkg::pick_class(mem_ff);
      too_big    = (cls >= NumClassesCode);
      zero_burst = (req_job_ff.burst == '0);
      cls_full   = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         sel_vec[c] = (cls == CLASS_W'(c));
         if (sel_vec[c] && q_full[c]) cls_full = 1'b1;
      end
      add_ok = !too_big && !zero_burst && !cls_full;
   end

   // dispatch: lowest non-empty class when the core is idle
   always_comb begin
      picked   = 1'b0;
      pick_job = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         pick_vec[c] = 1'b0;
         if (!busy_ff && !picked && q_head_vld[c]) begin
            pick_vec[c] = 1'b1;
            picked      = 1'b1;
            pick_job    = q_head_job[c];
         end
      end
      eff_busy = busy_ff || picked;
      eff_id   = busy_ff ? cur_id_ff  : pick_job.id;
      eff_rem  = busy_ff ? cur_rem_ff : pick_job.burst;
   end

   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         q_ctrl[c].job    = req_job_ff;
         q_ctrl[c].insert = do_exec && (cmd_ff == scsjd_pkg::CMD_ADD) && sel_vec[c] && add_ok;
         q_ctrl[c].pop    = do_exec && (cmd_ff == scsjd_pkg::CMD_TICK) && pick_vec[c];
      end
   end

   // result and core update
   always_comb begin
      busy_in       = busy_ff;
      cur_id_in     = cur_id_ff;
      cur_rem_in    = cur_rem_ff;
      rsp_status_in = scsjd_pkg::STAT_IDLE;
      rsp_id_in     = '0;
      rsp_rem_in    = '0;
      rsp_cls_in    = '0;
      if (cmd_ff == scsjd_pkg::CMD_ADD) begin
         priority if (too_big) begin
            rsp_status_in = scsjd_pkg::STAT_TOO_BIG;
         end else if (zero_burst) begin
            rsp_status_in = scsjd_pkg::STAT_ZERO_BURST;
            rsp_cls_in    = cls;
         end else if (cls_full) begin
            rsp_status_in = scsjd_pkg::STAT_CLASS_FULL;
            rsp_cls_in    = cls;
         end else begin
            rsp_status_in = scsjd_pkg::STAT_ADDED;
            rsp_cls_in    = cls;
         end
      end else if (!eff_busy) begin
         rsp_status_in = scsjd_pkg::STAT_IDLE;
      end else if (eff_rem <= BURST_W'(1)) begin
         busy_in       = 1'b0;
         cur_id_in     = eff_id;
         cur_rem_in    = '0;
         rsp_status_in = scsjd_pkg::STAT_FINISHED;
         rsp_id_in     = eff_id;
      end else begin
         busy_in       = 1'b1;
         cur_id_in     = eff_id;
         cur_rem_in    = eff_rem - BURST_W'(1);
         rsp_status_in = scsjd_pkg::STAT_RAN;
         rsp_id_in     = eff_id;
         rsp_rem_in    = eff_rem - BURST_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= scsjd_pkg::FSM_WAIT;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         cur_id_ff    <= '0;
         cur_rem_ff   <= '0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_exec) begin
            busy_ff    <= busy_in;
            cur_id_ff  <= cur_id_in;
            cur_rem_ff <= cur_rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         cmd_ff           <= scsjd_pkg::cmd_type'(req_tuser);
         req_job_ff.id    <= req_tdata[ID_W-1:0];
         req_job_ff.burst <= req_tdata[ID_W+BURST_W-1:ID_W];
         mem_ff           <= req_tdata[ID_W+BURST_W+MEM_W-1:ID_W+BURST_W];
      end
      if (do_exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_rem_ff    <= rsp_rem_in;
         rsp_cls_ff    <= rsp_cls_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = scsjd_pkg::RSP_TDATA_W'({rsp_cls_ff, rsp_rem_ff, rsp_id_ff});

endmodule

>>> design/scsjd_cell.sv
// One slot of a sorted job queue: holds a job and its occupancy bit.
// Shifts right on insert, left on pop. Depends on scsjd_pkg.
module scsjd_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  scsjd_pkg::queue_ctrl_type ctrl,
   input  logic                      left_ins,
   input  logic                      left_valid,
   input  scsjd_pkg::job_type        left_job,
   input  logic                      right_valid,
   input  scsjd_pkg::job_type        right_job,
   output logic                      ins,
   output logic                      valid,
   output scsjd_pkg::job_type        job
);

   logic               valid_ff, valid_in;
   scsjd_pkg::job_type job_ff, job_in;
   logic               goes_before;

   assign goes_before = (ctrl.job.burst < job_ff.burst) ||
                        ((ctrl.job.burst == job_ff.burst) && (ctrl.job.id < job_ff.id));
   assign ins   = !valid_ff || goes_before;
   assign valid = valid_ff;
   assign job   = job_ff;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      priority if (ctrl.pop) begin
         valid_in = right_valid;
         job_in   = right_job;
      end else if (ctrl.insert && left_ins) begin
         valid_in = left_valid;
         job_in   = left_job;
      end else if (ctrl.insert && ins) begin
         valid_in = 1'b1;
         job_in   = ctrl.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

>>> design/scsjd_queue.sv
// One size-class queue: a row of scsjd_cell slots kept sorted by burst, then id.
// Depends on scsjd_pkg and scsjd_cell.
module scsjd_queue #(
   parameter int DEPTH = scsjd_pkg::DEF_CLASS_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  scsjd_pkg::queue_ctrl_type ctrl,
   output logic                      head_valid,
   output scsjd_pkg::job_type        head_job,
   output logic                      full
);

   logic               ins_w   [DEPTH];
   logic               valid_w [DEPTH];
   scsjd_pkg::job_type job_w   [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic               l_ins, l_valid, r_valid;
         scsjd_pkg::job_type l_job, r_job;
         if (i == 0) begin : g_first
            assign l_ins   = 1'b0;
            assign l_valid = 1'b0;
            assign l_job   = '0;
         end else begin : g_mid
            assign l_ins   = ins_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_job   = job_w[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign r_valid = 1'b0;
            assign r_job   = '0;
         end else begin : g_inner
            assign r_valid = valid_w[i+1];
            assign r_job   = job_w[i+1];
         end
         scsjd_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_ins    (l_ins),
            .left_valid  (l_valid),
            .left_job    (l_job),
            .right_valid (r_valid),
            .right_job   (r_job),
            .ins         (ins_w[i]),
            .valid       (valid_w[i]),
            .job         (job_w[i])
         );
      end
   endgenerate

   assign head_valid = valid_w[0];
   assign head_job   = job_w[0];
   assign full       = valid_w[DEPTH-1];

endmodule
